// File: rtl/lrkm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrkm_pkg: shared types and constants for the longitudinal RF kick map.
// Holds the request and result structs, register indexes and the CORDIC
// angle table.
// ----------------------------------------------------------------------------
package lrkm_pkg;

    typedef struct packed {
        logic signed [31:0] time_offset;
        logic signed [31:0] energy_dev;
        logic               last_cell;
    } req_t;

    typedef struct packed {
        logic signed [31:0] new_energy;
        logic signed [31:0] new_time;
        logic               last_out;
        logic               saturated;
    } res_t;

    typedef enum logic [2:0] {
        REG_KICK_AMPLITUDE = 3'd0,
        REG_PHASE_GAIN     = 3'd1,
        REG_PHASE_OFFSET   = 3'd2,
        REG_ENERGY_LOSS    = 3'd3,
        REG_SLIP_FACTOR    = 3'd4
    } reg_idx_t;

    localparam logic signed [35:0] CORDIC_X0  = 36'sd652032874;
    localparam logic signed [35:0] SINE_LIMIT = 36'sd1073741824;

    // Angles in 2^-32 turn units, round(atan(2^-i) * 2^32 / (2 pi)).
    function automatic logic signed [35:0] turn_atan(input logic [4:0] i);
        logic signed [35:0] a;
        case (i)
            5'd0:  a = 36'sd536870912;
            5'd1:  a = 36'sd316933406;
            5'd2:  a = 36'sd167458907;
            5'd3:  a = 36'sd85004756;
            5'd4:  a = 36'sd42667331;
            5'd5:  a = 36'sd21354465;
            5'd6:  a = 36'sd10679838;
            5'd7:  a = 36'sd5340245;
            5'd8:  a = 36'sd2670163;
            5'd9:  a = 36'sd1335087;
            5'd10: a = 36'sd667544;
            5'd11: a = 36'sd333772;
            5'd12: a = 36'sd166886;
            5'd13: a = 36'sd83443;
            5'd14: a = 36'sd41722;
            5'd15: a = 36'sd20861;
            5'd16: a = 36'sd10430;
            5'd17: a = 36'sd5215;
            5'd18: a = 36'sd2608;
            5'd19: a = 36'sd1304;
            5'd20: a = 36'sd652;
            5'd21: a = 36'sd326;
            5'd22: a = 36'sd163;
            5'd23: a = 36'sd81;
            5'd24: a = 36'sd41;
            5'd25: a = 36'sd20;
            5'd26: a = 36'sd10;
            5'd27: a = 36'sd5;
            5'd28: a = 36'sd3;
            5'd29: a = 36'sd1;
            5'd30: a = 36'sd1;
            default: a = 36'sd0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/longitudinal_rf_kick_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longitudinal_rf_kick_map: one-turn RF kick and drift for a bunch slice.
// Pipelined phase product, CORDIC sine, kick product and saturating sums.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start with the req struct; busy is always low, so a
//   new slice may enter every clock cycle. Each request yields exactly one
//   result on res, marked by done for one cycle; the receiver cannot stall.
//   The pipeline runs through the phase product and offset, the CORDIC
//   (fold, rotations, clamp), the kick product and the saturating sums.
//   Throughput is one slice per cycle, set by the fully pipelined CORDIC.
//   Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
//   cfg_ready is always high. Write only while no slice is in flight.
//   Indexes beyond the register list are ignored.
//   Reset clears all configuration registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module longitudinal_rf_kick_map #(
    parameter int SINE_STAGES = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lrkm_pkg::req_t      req,
    output logic                done,
    output lrkm_pkg::res_t      res,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int SIDE_DEPTH = SINE_STAGES + 2;

    logic signed [31:0] kick_amplitude_reg;
    logic signed [31:0] phase_gain_reg;
    logic [31:0]        phase_offset_reg;
    logic signed [31:0] energy_loss_reg;
    logic signed [31:0] slip_factor_reg;

    logic               s1_valid_reg;
    logic signed [63:0] s1_prod_reg;
    logic signed [63:0] s1_drift_reg;
    logic signed [31:0] s1_time_reg;
    logic signed [31:0] s1_energy_reg;
    logic               s1_last_reg;

    logic               s2_valid_reg;
    logic [31:0]        s2_phase_reg;
    logic signed [39:0] s2_time_reg;
    logic signed [31:0] s2_energy_reg;
    logic               s2_last_reg;

    logic               sine_valid;
    logic signed [31:0] sine;
    logic [72:0]        side_d;
    logic [72:0]        side_q;
    logic signed [39:0] dl_time;
    logic signed [31:0] dl_energy;
    logic               dl_last;

    logic               s3_valid_reg;
    logic signed [63:0] s3_kick_reg;
    logic signed [39:0] s3_time_reg;
    logic signed [31:0] s3_energy_reg;
    logic               s3_last_reg;

    logic               out_valid_reg;
    lrkm_pkg::res_t     out_reg;
    lrkm_pkg::res_t     out_next;
    logic signed [34:0] energy_sum;
    logic               e_hi, e_lo, t_hi, t_lo;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kick_amplitude_reg <= '0;
            phase_gain_reg     <= '0;
            phase_offset_reg   <= '0;
            energy_loss_reg    <= '0;
            slip_factor_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lrkm_pkg::REG_KICK_AMPLITUDE: kick_amplitude_reg <= cfg_data;
                lrkm_pkg::REG_PHASE_GAIN:     phase_gain_reg     <= cfg_data;
                lrkm_pkg::REG_PHASE_OFFSET:   phase_offset_reg   <= cfg_data;
                lrkm_pkg::REG_ENERGY_LOSS:    energy_loss_reg    <= cfg_data;
                lrkm_pkg::REG_SLIP_FACTOR:    slip_factor_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= start && !busy;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= sine_valid;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg   <= 64'(phase_gain_reg) * 64'(req.time_offset);
        s1_drift_reg  <= 64'(req.energy_dev) * 64'(slip_factor_reg);
        s1_time_reg   <= req.time_offset;
        s1_energy_reg <= req.energy_dev;
        s1_last_reg   <= req.last_cell;

        s2_phase_reg  <= s1_prod_reg[47:16] + phase_offset_reg;
        // The drift is floored by the arithmetic shift and fits in 40 bits, and
        // so does the difference; it is clipped in the last stage.
        s2_time_reg   <= 40'(s1_time_reg) - 40'(s1_drift_reg >>> 24);
        s2_energy_reg <= s1_energy_reg;
        s2_last_reg   <= s1_last_reg;
    end

    lrkm_cordic #(
        .STAGES (SINE_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .phase     (s2_phase_reg),
        .out_valid (sine_valid),
        .sine      (sine)
    );

    assign side_d = {s2_time_reg, s2_energy_reg, s2_last_reg};

    lrkm_delay #(
        .WIDTH (73),
        .DEPTH (SIDE_DEPTH)
    ) u_side (
        .clk (clk),
        .d   (side_d),
        .q   (side_q)
    );

    assign dl_time   = side_q[72:33];
    assign dl_energy = side_q[32:1];
    assign dl_last   = side_q[0];

    always_ff @(posedge clk)
    begin
        s3_kick_reg   <= 64'(kick_amplitude_reg) * 64'(sine);
        s3_time_reg   <= dl_time;
        s3_energy_reg <= dl_energy;
        s3_last_reg   <= dl_last;
    end

    always_comb
    begin
        energy_sum = 35'(s3_energy_reg) + 35'(s3_kick_reg >>> 30)
                   - 35'(energy_loss_reg);
        e_hi = energy_sum > 35'sd2147483647;
        e_lo = energy_sum < -35'sd2147483648;
        t_hi = s3_time_reg > 40'sd2147483647;
        t_lo = s3_time_reg < -40'sd2147483648;
        out_next.new_energy = e_hi ? 32'sh7fffffff : e_lo ? 32'sh80000000
                                   : energy_sum[31:0];
        out_next.new_time   = t_hi ? 32'sh7fffffff : t_lo ? 32'sh80000000
                                   : s3_time_reg[31:0];
        out_next.last_out   = s3_last_reg;
        out_next.saturated  = e_hi || e_lo || t_hi || t_lo;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done = out_valid_reg;
    assign res  = out_reg;

    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done && res.saturated |-> res.new_energy == 32'sh7fffffff
            || res.new_energy == 32'sh80000000
            || res.new_time == 32'sh7fffffff
            || res.new_time == 32'sh80000000)
        else $error("saturation flag inconsistent");
    a_sine_follows: assert property (@(posedge clk) disable iff (!rst_n)
        sine_valid |=> s3_valid_reg)
        else $error("kick stage lost a slice");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |=> done)
        else $error("result stage lost a slice");
    a_front_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> s1_valid_reg)
        else $error("phase stage lost a slice");

endmodule

// File: rtl/lrkm_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrkm_cordic: pipelined rotation-mode CORDIC sine.
// Folds the phase into a quarter turn, runs one micro-rotation per register
// stage and clamps the sine to [-2^30, 2^30] in Q2.30.
// ----------------------------------------------------------------------------
module lrkm_cordic #(
    parameter int STAGES = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [31:0]        phase,
    output logic               out_valid,
    output logic signed [31:0] sine
);

    logic                      fold_valid_reg;
    logic signed [35:0]        fold_z_reg;
    logic signed [35:0]        z_ph;
    logic signed [35:0]        z_fold;

    logic [STAGES-1:0]         v_reg;
    logic signed [35:0]        x_reg [STAGES];
    logic signed [35:0]        y_reg [STAGES];
    logic signed [35:0]        z_reg [STAGES];

    logic                      sine_valid_reg;
    logic signed [31:0]        sine_reg;
    logic signed [35:0]        y_last;
    logic signed [31:0]        sine_next;

    always_comb
    begin
        z_ph = 36'(signed'(phase));
        if (z_ph > lrkm_pkg::SINE_LIMIT)
            z_fold = 36'sd2147483648 - z_ph;
        else if (z_ph < -lrkm_pkg::SINE_LIMIT)
            z_fold = -36'sd2147483648 - z_ph;
        else
            z_fold = z_ph;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_valid_reg <= 1'b0;
        else
            fold_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        fold_z_reg <= z_fold;
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [35:0] xi;
        logic signed [35:0] yi;
        logic signed [35:0] zi;
        logic               vi;
        logic signed [35:0] angle;

        if (i == 0) begin : g_first
            assign xi = lrkm_pkg::CORDIC_X0;
            assign yi = '0;
            assign zi = fold_z_reg;
            assign vi = fold_valid_reg;
        end else begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign vi = v_reg[i-1];
        end

        assign angle = lrkm_pkg::turn_atan(5'(i));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else
                v_reg[i] <= vi;
        end

        // Arithmetic shifts floor, matching the fixed-point rotation.
        always_ff @(posedge clk)
        begin
            if (!zi[35])
            begin
                x_reg[i] <= xi - (yi >>> i);
                y_reg[i] <= yi + (xi >>> i);
                z_reg[i] <= zi - angle;
            end
            else
            begin
                x_reg[i] <= xi + (yi >>> i);
                y_reg[i] <= yi - (xi >>> i);
                z_reg[i] <= zi + angle;
            end
        end
    end

    always_comb
    begin
        y_last = y_reg[STAGES-1];
        if (y_last > lrkm_pkg::SINE_LIMIT)
            sine_next = 32'sd1073741824;
        else if (y_last < -lrkm_pkg::SINE_LIMIT)
            sine_next = -32'sd1073741824;
        else
            sine_next = y_last[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sine_valid_reg <= 1'b0;
        else
            sine_valid_reg <= v_reg[STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        sine_reg <= sine_next;
    end

    assign out_valid = sine_valid_reg;
    assign sine      = sine_reg;

endmodule

// File: rtl/lrkm_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrkm_delay: fixed-length shift line for side data.
// Carries the drifted time and the slice fields alongside the sine pipeline.
// ----------------------------------------------------------------------------
module lrkm_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= d;
        for (int i = 1; i < DEPTH; i++)
            tap_reg[i] <= tap_reg[i-1];
    end

    assign q = tap_reg[DEPTH-1];

endmodule
